// ===== hw/rtl/lpbd_pkg.sv =====
// Package for the LRU page buffer directory: sizes, action and status codes,
// and the packed transaction types. No dependencies.
package lpbd_pkg;

  localparam int Frames    = 16;
  localparam int PageBits  = 32;
  localparam int Tables    = 10;
  localparam int FrameBits = $clog2(Frames);
  localparam int QueueDepth = 2;

  localparam logic [1:0] ACT_LOOKUP    = 2'd0;
  localparam logic [1:0] ACT_MARK      = 2'd1;
  localparam logic [1:0] ACT_FLUSH_TBL = 2'd2;
  localparam logic [1:0] ACT_FLUSH_ALL = 2'd3;

  localparam logic [2:0] ST_HIT    = 3'd0;
  localparam logic [2:0] ST_MISS   = 3'd1;
  localparam logic [2:0] ST_MARKED = 3'd2;
  localparam logic [2:0] ST_ABSENT = 3'd3;
  localparam logic [2:0] ST_FLUSH  = 3'd4;

  typedef struct packed {
    logic [1:0]          action;
    logic [3:0]          tbl_num;
    logic [PageBits-1:0] page_idx;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [3:0]          frame;
    logic                writeback_valid;
    logic [3:0]          writeback_table;
    logic [PageBits-1:0] writeback_page;
    logic                last;
  } out_item_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic [1:0]          action;
    logic                tvalid;
    logic [3:0]          tbl_num;
    logic [PageBits-1:0] page_idx;
  } cmd_t;

endpackage

// ===== hw/rtl/lpbd_front.sv =====
// Front end of the LRU page buffer directory: accepts commands, checks the
// table number and queues them for the back end. Uses lpbd_pkg.
module lpbd_front
  import lpbd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  in_item_t in_item,
  output logic     busy,
  output logic     q_valid,
  output cmd_t     q_cmd,
  input  logic     q_pop
);

  localparam int CntBits = $clog2(QueueDepth + 1);
  localparam int PtrBits = $clog2(QueueDepth);

  cmd_t                q_mem [QueueDepth];
  logic [PtrBits-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CntBits-1:0]  cnt_r, cnt_nxt;
  logic                push;
  cmd_t                cmd_in;

  assign busy    = (cnt_r == CntBits'(QueueDepth));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_cmd   = q_mem[rd_ptr_r];

  always_comb begin
    cmd_in.action   = in_item.action;
    cmd_in.tbl_num  = in_item.tbl_num;
    cmd_in.page_idx = in_item.page_idx;
    cmd_in.tvalid   = (in_item.tbl_num != 4'd0) && (in_item.tbl_num <= 4'(Tables));
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// ===== hw/rtl/lpbd_back.sv =====
// Back end of the LRU page buffer directory: frame tags, dirty bits, LRU
// ranks, the parallel tag compare and the flush scan. Uses lpbd_pkg.
module lpbd_back
  import lpbd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]           state_r, state_nxt;
  cmd_t                 cmd_r;
  logic [3:0]           tag_r   [Frames];
  logic [PageBits-1:0]  page_r  [Frames];
  logic                 dirty_r [Frames];
  logic [FrameBits-1:0] rank_r  [Frames];
  logic [Frames-1:0]    scan_r;
  logic                 hit_r;
  logic [FrameBits-1:0] hit_idx_r, lru_idx_r;

  logic [Frames-1:0]    match_c;
  logic [FrameBits-1:0] hit_idx_c, lru_idx_c, tgt, sel;
  logic [Frames-1:0]    scan_c, scan_left;
  logic                 scan_any;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_r, out_nxt;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign q_pop     = (state_r == S_IDLE) && q_valid;

  // Tag compare and LRU search over the queued command.
  always_comb begin
    hit_idx_c = '0;
    lru_idx_c = '0;
    for (int i = 0; i < Frames; i++) begin
      match_c[i] = (tag_r[i] != 4'd0) && (tag_r[i] == q_cmd.tbl_num)
                   && (page_r[i] == q_cmd.page_idx);
      if (q_cmd.action == ACT_FLUSH_TBL) begin
        scan_c[i] = q_cmd.tvalid && (tag_r[i] == q_cmd.tbl_num);
      end else begin
        scan_c[i] = (tag_r[i] != 4'd0);
      end
    end
    for (int i = Frames - 1; i >= 0; i--) begin
      if (match_c[i]) begin
        hit_idx_c = FrameBits'(i);
      end
      if (rank_r[i] == FrameBits'(Frames - 1)) begin
        lru_idx_c = FrameBits'(i);
      end
    end
  end

  // Lowest pending frame of the flush scan.
  always_comb begin
    sel = '0;
    for (int i = Frames - 1; i >= 0; i--) begin
      if (scan_r[i]) begin
        sel = FrameBits'(i);
      end
    end
    scan_left = scan_r;
    scan_left[sel] = 1'b0;
    scan_any = |scan_r;
  end

  assign tgt = hit_r ? hit_idx_r : lru_idx_r;
  assign out_valid_nxt = (state_r == S_EXEC) || ((state_r == S_SCAN) && scan_any);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_cmd.action == ACT_LOOKUP || q_cmd.action == ACT_MARK)
                      ? S_EXEC : S_SCAN;
        end
      end
      S_EXEC: state_nxt = S_IDLE;
      S_SCAN: begin
        if (scan_left == '0) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < Frames; i++) begin
        tag_r[i]   <= 4'd0;
        page_r[i]  <= '1;
        dirty_r[i] <= 1'b0;
        rank_r[i]  <= FrameBits'(i);
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      case (state_r)
        S_EXEC: begin
          if (cmd_r.action == ACT_MARK && cmd_r.tvalid && hit_r) begin
            dirty_r[hit_idx_r] <= 1'b1;
          end else if (cmd_r.action == ACT_LOOKUP && cmd_r.tvalid) begin
            for (int i = 0; i < Frames; i++) begin
              if (rank_r[i] < rank_r[tgt]) begin
                rank_r[i] <= rank_r[i] + 1'b1;
              end
            end
            rank_r[tgt] <= '0;
            if (!hit_r) begin
              tag_r[tgt]   <= cmd_r.tbl_num;
              page_r[tgt]  <= cmd_r.page_idx;
              dirty_r[tgt] <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          if (scan_any && cmd_r.action == ACT_FLUSH_TBL) begin
            tag_r[sel]   <= 4'd0;
            page_r[sel]  <= '1;
            dirty_r[sel] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r     <= q_cmd;
      hit_r     <= |match_c;
      hit_idx_r <= hit_idx_c;
      lru_idx_r <= lru_idx_c;
      scan_r    <= scan_c;
    end else if (state_r == S_SCAN) begin
      scan_r <= scan_left;
    end
  end

  // Result payload.
  always_comb begin
    out_nxt = '0;
    out_nxt.last = 1'b1;
    if (state_r == S_EXEC) begin
      if (!cmd_r.tvalid || (cmd_r.action == ACT_MARK && !hit_r)) begin
        out_nxt.status = ST_ABSENT;
      end else if (cmd_r.action == ACT_MARK) begin
        out_nxt.status = ST_MARKED;
        out_nxt.frame  = 4'(hit_idx_r);
      end else if (hit_r) begin
        out_nxt.status = ST_HIT;
        out_nxt.frame  = 4'(hit_idx_r);
      end else begin
        out_nxt.status = ST_MISS;
        out_nxt.frame  = 4'(lru_idx_r);
        if (dirty_r[lru_idx_r] && tag_r[lru_idx_r] != 4'd0) begin
          out_nxt.writeback_valid = 1'b1;
          out_nxt.writeback_table = tag_r[lru_idx_r];
          out_nxt.writeback_page  = page_r[lru_idx_r];
        end
      end
    end else begin
      out_nxt.status          = ST_FLUSH;
      out_nxt.frame           = 4'(sel);
      out_nxt.writeback_valid = 1'b1;
      out_nxt.writeback_table = tag_r[sel];
      out_nxt.writeback_page  = page_r[sel];
      out_nxt.last            = (scan_left == '0);
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

// ===== hw/rtl/lru_page_buffer_directory.sv =====
// Top level of the LRU page buffer directory: a command front end and a
// directory back end joined by a two-entry queue. Uses lpbd_pkg.
//
// Usage: present a command on in_item and raise start; it is taken at a
// clock edge where busy is low. Commands are lookup, mark dirty, flush one
// table and flush all. Each result appears on out_item for one cycle with
// out_valid high; out_item.last marks the final result of a command.
// Lookups and dirty marks give one result: the back end picks the command
// from the queue and registers the compare of all frame tags, then updates
// the tags, dirty bits and LRU ranks and registers the result. It takes no
// new command until it is done with the last. Flushes give one result per
// reported frame and no result when nothing matches. The queue lets new
// commands be taken while the back end works; busy rises only when it is
// full. Reset empties every frame, clears dirty bits and sets the LRU order
// to frame 0 most recent. The receiver cannot stall.
module lru_page_buffer_directory
  import lpbd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_item,
  output logic      busy,
  output logic      out_valid,
  output out_item_t out_item
);

  logic q_valid, q_pop;
  cmd_t q_cmd;

  lpbd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .busy    (busy),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  lpbd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the LRU page buffer directory: directed table of
// commands, then random traffic, checked against an in-bench directory model.
// Depends on lpbd_pkg and lru_page_buffer_directory.
module testbench;
  import lpbd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  lru_page_buffer_directory dut (
    .clk(clk), .rst_n(rst_n), .start(start), .in_item(in_item),
    .busy(busy), .out_valid(out_valid), .out_item(out_item)
  );

  always #5 clk = ~clk;

  // Mirror of the directory contents.
  logic [3:0]          dir_table [Frames];
  logic [PageBits-1:0] dir_page  [Frames];
  logic                dir_dirty [Frames];
  int unsigned         dir_rank  [Frames];

  out_item_t expected_results[$];
  int        error_count = 0;
  int        idle_pct = 0;

  // Directed rows: a typed-in result is checked against the model's prediction.
  typedef struct {
    in_item_t  cmd;
    logic      has_fixed;
    out_item_t fixed;
  } row_t;

  function automatic out_item_t mk_res(logic [2:0] st, logic [3:0] fr, logic wv,
                                       logic [3:0] wt, logic [PageBits-1:0] wp,
                                       logic lst);
    out_item_t r;
    r.status = st; r.frame = fr; r.writeback_valid = wv;
    r.writeback_table = wt; r.writeback_page = wp; r.last = lst;
    return r;
  endfunction

  function automatic in_item_t mk_cmd(logic [1:0] a, logic [3:0] t,
                                      logic [PageBits-1:0] p);
    in_item_t c;
    c.action = a; c.tbl_num = t; c.page_idx = p;
    return c;
  endfunction

  task automatic clear_directory();
    for (int i = 0; i < Frames; i++) begin
      dir_table[i] = '0; dir_page[i] = '1; dir_dirty[i] = 1'b0; dir_rank[i] = i;
    end
  endtask

  task automatic promote_frame(int f);
    int unsigned r;
    r = dir_rank[f];
    for (int j = 0; j < Frames; j++)
      if (dir_rank[j] < r) dir_rank[j]++;
    dir_rank[f] = 0;
  endtask

  // Applies one command to the mirror and queues the results it causes.
  task automatic predict_directory(in_item_t c);
    logic tv;
    int   f;
    int   first;
    tv = (c.tbl_num >= 1) && (c.tbl_num <= Tables);
    f = -1;
    if (c.action == ACT_LOOKUP || c.action == ACT_MARK) begin
      if (!tv) begin
        expected_results.push_back(mk_res(ST_ABSENT, 0, 0, 0, 0, 1));
        return;
      end
      for (int i = Frames - 1; i >= 0; i--)
        if (dir_table[i] != 0 && dir_table[i] == c.tbl_num && dir_page[i] == c.page_idx)
          f = i;
      if (c.action == ACT_MARK) begin
        if (f < 0) expected_results.push_back(mk_res(ST_ABSENT, 0, 0, 0, 0, 1));
        else begin
          dir_dirty[f] = 1'b1;
          expected_results.push_back(mk_res(ST_MARKED, 4'(f), 0, 0, 0, 1));
        end
      end else if (f >= 0) begin
        promote_frame(f);
        expected_results.push_back(mk_res(ST_HIT, 4'(f), 0, 0, 0, 1));
      end else begin
        f = 0;
        for (int i = 1; i < Frames; i++) if (dir_rank[i] > dir_rank[f]) f = i;
        if (dir_dirty[f] && dir_table[f] != 0)
          expected_results.push_back(mk_res(ST_MISS, 4'(f), 1, dir_table[f],
                                            dir_page[f], 1));
        else
          expected_results.push_back(mk_res(ST_MISS, 4'(f), 0, 0, 0, 1));
        promote_frame(f);
        dir_table[f] = c.tbl_num; dir_page[f] = c.page_idx; dir_dirty[f] = 1'b0;
      end
    end else begin
      first = expected_results.size();
      for (int i = 0; i < Frames; i++) begin
        if (c.action == ACT_FLUSH_TBL ? (tv && dir_table[i] == c.tbl_num)
                                      : (dir_table[i] != 0)) begin
          expected_results.push_back(mk_res(ST_FLUSH, 4'(i), 1, dir_table[i],
                                            dir_page[i], 0));
          if (c.action == ACT_FLUSH_TBL) begin
            dir_table[i] = '0; dir_page[i] = '1; dir_dirty[i] = 1'b0;
          end
        end
      end
      if (expected_results.size() > first)
        expected_results[expected_results.size() - 1].last = 1'b1;
    end
  endtask

  // Holds start up until the command is taken, idling first at random.
  task automatic issue_command(in_item_t c);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= c;
    do @(posedge clk); while (busy);
    predict_directory(c);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: %p", out_item);
        error_count++;
      end else begin
        out_item_t e;
        e = expected_results.pop_front();
        if (out_item.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_item.status); error_count++;
        end
        if (out_item.frame !== e.frame) begin
          $error("frame: expected %0d, got %0d", e.frame, out_item.frame); error_count++;
        end
        if (out_item.writeback_valid !== e.writeback_valid) begin
          $error("writeback_valid: expected %0b, got %0b", e.writeback_valid,
                 out_item.writeback_valid);
          error_count++;
        end
        if (out_item.writeback_table !== e.writeback_table) begin
          $error("writeback_table: expected %0d, got %0d", e.writeback_table,
                 out_item.writeback_table);
          error_count++;
        end
        if (out_item.writeback_page !== e.writeback_page) begin
          $error("writeback_page: expected %h, got %h", e.writeback_page,
                 out_item.writeback_page);
          error_count++;
        end
        if (out_item.last !== e.last) begin
          $error("last: expected %0b, got %0b", e.last, out_item.last); error_count++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("[lru_page_buffer_directory] ERROR");
    $finish;
  end

  initial begin
    row_t      rows[$];
    row_t      r;
    in_item_t  c;
    out_item_t snap;
    int        sel;
    logic [PageBits-1:0] hot_pages[8];

    clear_directory();
    r.has_fixed = 1'b0; r.fixed = '0;
    // Empty directory: flushes report nothing, first miss takes frame 15.
    r.cmd = mk_cmd(ACT_FLUSH_ALL, 1, 0); rows.push_back(r);
    r.cmd = mk_cmd(ACT_MARK, 1, 0); r.has_fixed = 1'b1;
    r.fixed = mk_res(ST_ABSENT, 0, 0, 0, 0, 1);
    rows.push_back(r);
    r.cmd = mk_cmd(ACT_LOOKUP, 1, '1); r.fixed = mk_res(ST_MISS, 15, 0, 0, 0, 1);
    rows.push_back(r);
    r.cmd = mk_cmd(ACT_LOOKUP, 0, 5); r.fixed = mk_res(ST_ABSENT, 0, 0, 0, 0, 1);
    rows.push_back(r);
    r.cmd = mk_cmd(ACT_MARK, 15, 5); rows.push_back(r);
    r.cmd = mk_cmd(ACT_LOOKUP, 11, 5); rows.push_back(r);
    r.has_fixed = 1'b0;
    r.cmd = mk_cmd(ACT_LOOKUP, 10, 0); rows.push_back(r);
    r.cmd = mk_cmd(ACT_LOOKUP, 1, '1); rows.push_back(r);
    r.cmd = mk_cmd(ACT_MARK, 1, '1); rows.push_back(r);
    r.cmd = mk_cmd(ACT_LOOKUP, 5, 32'hAAAA_5555); rows.push_back(r);
    r.cmd = mk_cmd(ACT_LOOKUP, 5, 32'h5555_AAAA); rows.push_back(r);
    r.cmd = mk_cmd(ACT_MARK, 5, 32'h5555_AAAA); rows.push_back(r);
    r.cmd = mk_cmd(ACT_FLUSH_ALL, 0, 0); rows.push_back(r);
    r.cmd = mk_cmd(ACT_FLUSH_TBL, 15, 0); rows.push_back(r);
    r.cmd = mk_cmd(ACT_FLUSH_TBL, 0, 0); rows.push_back(r);
    r.cmd = mk_cmd(ACT_FLUSH_TBL, 5, 0); rows.push_back(r);
    // Fill past capacity so dirty victims get written back.
    for (int i = 0; i < 18; i++) begin
      r.cmd = mk_cmd(ACT_LOOKUP, 4'(2 + (i % 3)), PageBits'(i)); rows.push_back(r);
      if (i < 3) begin
        r.cmd = mk_cmd(ACT_MARK, 4'(2 + (i % 3)), PageBits'(i)); rows.push_back(r);
      end
    end
    r.cmd = mk_cmd(ACT_FLUSH_ALL, 0, 0); rows.push_back(r);
    r.cmd = mk_cmd(ACT_FLUSH_TBL, 3, 0); rows.push_back(r);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      issue_command(rows[i].cmd);
      if (rows[i].has_fixed) begin
        snap = expected_results[expected_results.size() - 1];
        if (snap !== rows[i].fixed) begin
          $error("directed row %0d: expected %p, got %p", i, rows[i].fixed, snap);
          error_count++;
        end
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 75 : (phase == 3 ? 6 : 0);
      for (int k = 0; k < 8; k++) hot_pages[k] = $urandom();
      hot_pages[0] = '1; hot_pages[1] = '0;
      for (int n = 0; n < 85; n++) begin
        sel = $urandom_range(99);
        c.page_idx = ($urandom_range(3) == 0) ? $urandom() : hot_pages[$urandom_range(7)];
        c.tbl_num = ($urandom_range(19) == 0) ? 4'($urandom_range(15))
                                              : 4'($urandom_range(1, 4));
        if (sel < 60) c.action = ACT_LOOKUP;
        else if (sel < 85) c.action = ACT_MARK;
        else if (sel < 93) c.action = ACT_FLUSH_TBL;
        else c.action = ACT_FLUSH_ALL;
        issue_command(c);
      end
    end
    start <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0) $display("[lru_page_buffer_directory] OK");
    else $display("[lru_page_buffer_directory] ERROR");
    $finish;
  end
endmodule
